// ===== src/tcw_pkg.sv =====
// Shared types, command codes and defaults for the text console writer.
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int ADDR_FIELD_W = 11;
    localparam int CELL_W       = 16;

    // Reciprocal scaling for row = address / COLUMNS on an 11-bit address.
    localparam int RECIP_SHIFT = 20;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_RENDER = 2'd3;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [3:0] NIBBLE_MASK  = 4'h0F;

    typedef struct packed {
        logic [1:0]              command;
        logic [7:0]              char_code;
        logic [3:0]              fg_color;
        logic [3:0]              bg_color;
        logic [ADDR_FIELD_W-1:0] read_address;
    } t_cmd_in;

    typedef struct packed {
        logic [ADDR_FIELD_W-1:0] cursor_index;
        logic [CELL_W-1:0]       read_cell;
    } t_result;

    // Classified item passed from the front end to the sequencer.
    typedef struct packed {
        logic [1:0]              command;
        logic                    is_newline;
        logic [CELL_W-1:0]       cell_value;
        logic [ADDR_FIELD_W-1:0] read_address;
        logic                    out_of_range;
        logic [ADDR_FIELD_W-1:0] read_row;
    } t_item;

endpackage

// ===== src/text_console_writer.sv =====
// Text console writer top level: front end, command queue and cell store sequencer.
//
//   channel | direction | handshake            | beat
//   --------+-----------+----------------------+------------------------------------
//   in      | input     | i_in_valid/o_in_stall | command, char, colors, read address
//   out     | output    | o_out_valid/i_out_stall | cursor index, read cell
//
// Path: the front-end register, then the sequencer states: newline, clear and render go
// straight to DONE, a stored character passes WRITE and a read passes READ1 and READ2
// before DONE, and DONE loads the result register. The sequencer handles one item at a
// time and pops no new item until it is back in IDLE. Reset clears the per-row valid
// bits at once, with no sweep of the store. A stalled output holds the sequencer; the
// queue keeps taking beats until it fills.
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  tcw_pkg::t_cmd_in i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output tcw_pkg::t_result o_out_data
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = ROWS * COLUMNS;

    logic  q_push;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;
    t_item front_item;
    t_item q_item;

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_stall  (o_in_stall),
        .i_data   (i_in_data),
        .o_push   (q_push),
        .o_item   (front_item),
        .i_q_full (q_full)
    );

    tcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Cursor never passes one past the last cell.
    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_out_data.cursor_index) <= 32'(CELL_COUNT)))
        else $error("cursor index beyond cell count");

    // Front end only stalls when the queue is full.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> q_full)
        else $error("input stalled with queue space free");

    // Sequencer never takes two items in back-to-back cycles.
    a_pop_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> !q_pop)
        else $error("queue popped on consecutive cycles");

    // Nothing is popped from an empty queue.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

endmodule

// ===== src/tcw_front.sv =====
// Front end: takes command beats, decodes them and splits read addresses into rows.
module tcw_front #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  tcw_pkg::t_cmd_in i_data,
    output logic             o_push,
    output tcw_pkg::t_item   o_item,
    input  logic             i_q_full
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int PROD_W     = ADDR_FIELD_W + RECIP_SHIFT;
    localparam logic [RECIP_SHIFT-1:0] RECIP_VAL =
        RECIP_SHIFT'((1 << RECIP_SHIFT) / COLUMNS + 1);

    logic           r_valid;
    t_item          r_item;
    t_item          n_item;
    logic [PROD_W-1:0] row_prod;

    // Exact for every 11-bit address while COLUMNS is between 2 and 255.
    assign row_prod = {{RECIP_SHIFT{1'b0}}, i_data.read_address}
                    * {{ADDR_FIELD_W{1'b0}}, RECIP_VAL};

    always_comb begin
        n_item.command      = i_data.command;
        n_item.is_newline   = (i_data.char_code == NEWLINE_CODE);
        n_item.cell_value   = {i_data.bg_color & NIBBLE_MASK,
                               i_data.fg_color & NIBBLE_MASK,
                               i_data.char_code};
        n_item.read_address = i_data.read_address;
        n_item.out_of_range = ({21'd0, i_data.read_address} >= 32'(CELL_COUNT));
        n_item.read_row     = row_prod[PROD_W-1:RECIP_SHIFT];
    end

    assign o_stall = r_valid & i_q_full;
    assign o_push  = r_valid & ~i_q_full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== src/tcw_queue.sv =====
// Two-entry queue between the front end and the sequencer.
module tcw_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tcw_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output tcw_pkg::t_item o_item
);
    import tcw_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== src/tcw_back.sv =====
// Sequencer: cursor, ring-buffered cell store with lazy row clearing, result register.
module tcw_back #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  tcw_pkg::t_item   i_q_item,
    output logic             o_q_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output tcw_pkg::t_result o_out_data
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COL_W      = $clog2(COLUMNS + 1);

    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0] LAST_BASE  = ADDR_W'(CELL_COUNT - COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
    localparam logic [COL_W-1:0]  WRAP_COL   = COL_W'(COLUMNS);
    localparam logic [ROW_W:0]    ROWS_V     = (ROW_W + 1)'(ROWS);
    localparam logic [ADDR_W:0]   CELLS_V    = (ADDR_W + 1)'(CELL_COUNT);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WRITE = 3'd1;
    localparam logic [2:0] ST_READ1 = 3'd2;
    localparam logic [2:0] ST_READ2 = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]        r_state;
    t_item             r_item;
    logic [ROW_W-1:0]  r_row;        // logical cursor row
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_cur_phys;   // physical row under the cursor
    logic [ADDR_W-1:0] r_row_base;   // physical address of the cursor row
    logic [ROW_W-1:0]  r_base;       // physical row shown as logical row 0
    logic [ADDR_W-1:0] r_base_off;
    logic [ADDR_W-1:0] r_lin_row;    // r_row * COLUMNS
    logic [ROWS-1:0]   r_row_valid;
    logic              r_rd_vld;
    logic [COL_W-1:0]  r_rd_col;
    logic [CELL_W-1:0] r_rd_cell;
    logic              r_out_valid;
    t_result           r_out_data;

    logic [CELL_W-1:0] cell_mem [CELL_COUNT];
    logic [COL_W-1:0]  fill_mem [ROWS];   // cells written in the row since it was cleared
    logic [CELL_W-1:0] r_cell_q;
    logic [COL_W-1:0]  r_fill_q;

    logic              wrap_pending;
    logic              adv_row;
    logic              out_free;
    logic [ROW_W-1:0]  phys_nxt;
    logic [ROW_W-1:0]  base_nxt;
    logic [ADDR_W-1:0] row_base_nxt;
    logic [ADDR_W-1:0] base_off_nxt;
    logic [ROW_W-1:0]  rd_row;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] rd_row_off;
    logic [COL_W-1:0]  rd_col;
    logic [ROW_W:0]    rd_phys_sum;
    logic [ROW_W-1:0]  rd_phys;
    logic [ADDR_W:0]   rd_lin_sum;
    logic [ADDR_W-1:0] rd_lin;
    logic [ADDR_W:0]   cur_sum;

    assign wrap_pending = (r_col == WRAP_COL);
    assign o_q_pop      = (r_state == ST_IDLE) && i_q_valid;
    assign out_free     = !r_out_valid || !i_out_stall;

    always_comb begin
        adv_row = 1'b0;
        if (o_q_pop) begin
            case (i_q_item.command)
                CMD_WRITE:  adv_row = i_q_item.is_newline || wrap_pending;
                CMD_RENDER: adv_row = wrap_pending;
                default:    adv_row = 1'b0;
            endcase
        end
    end

    assign phys_nxt     = (r_cur_phys == LAST_ROW) ? '0 : r_cur_phys + 1'b1;
    assign base_nxt     = (r_base == LAST_ROW) ? '0 : r_base + 1'b1;
    assign row_base_nxt = (r_row_base == LAST_BASE) ? '0 : r_row_base + ROW_STRIDE;
    assign base_off_nxt = (r_base_off == LAST_BASE) ? '0 : r_base_off + ROW_STRIDE;

    // Logical read address to physical row and address through the ring base.
    assign rd_row      = ROW_W'(r_item.read_row);
    assign rd_addr     = ADDR_W'(r_item.read_address);
    assign rd_row_off  = ADDR_W'(rd_row * COLUMNS);
    assign rd_col      = COL_W'(rd_addr - rd_row_off);
    assign rd_phys_sum = {1'b0, rd_row} + {1'b0, r_base};
    assign rd_phys     = (rd_phys_sum >= ROWS_V) ? ROW_W'(rd_phys_sum - ROWS_V)
                                                 : ROW_W'(rd_phys_sum);
    assign rd_lin_sum  = {1'b0, rd_addr} + {1'b0, r_base_off};
    assign rd_lin      = (rd_lin_sum >= CELLS_V) ? ADDR_W'(rd_lin_sum - CELLS_V)
                                                 : ADDR_W'(rd_lin_sum);

    assign cur_sum = {1'b0, r_lin_row} + (ADDR_W + 1)'(r_col);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WRITE) begin
            cell_mem[r_row_base + ADDR_W'(r_col)] <= r_item.cell_value;
            fill_mem[r_cur_phys] <= r_col + 1'b1;
        end
        r_cell_q <= cell_mem[rd_lin];
        r_fill_q <= fill_mem[rd_phys];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_cur_phys  <= '0;
            r_row_base  <= '0;
            r_base      <= '0;
            r_base_off  <= '0;
            r_lin_row   <= '0;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (adv_row) begin
                // Entered row is always fresh: scrolled-in or never written since clear.
                r_col                 <= '0;
                r_cur_phys            <= phys_nxt;
                r_row_base            <= row_base_nxt;
                r_row_valid[phys_nxt] <= 1'b0;
                if (r_row == LAST_ROW) begin
                    r_base     <= base_nxt;
                    r_base_off <= base_off_nxt;
                end else begin
                    r_row     <= r_row + 1'b1;
                    r_lin_row <= r_lin_row + ROW_STRIDE;
                end
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        case (i_q_item.command)
                            CMD_WRITE: begin
                                r_state <= i_q_item.is_newline ? ST_DONE : ST_WRITE;
                            end
                            CMD_CLEAR: begin
                                r_row       <= '0;
                                r_col       <= '0;
                                r_cur_phys  <= '0;
                                r_row_base  <= '0;
                                r_base      <= '0;
                                r_base_off  <= '0;
                                r_lin_row   <= '0;
                                r_row_valid <= '0;
                                r_state     <= ST_DONE;
                            end
                            CMD_READ: begin
                                r_state <= ST_READ1;
                            end
                            default: begin
                                r_state <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_WRITE: begin
                    r_col                   <= r_col + 1'b1;
                    r_row_valid[r_cur_phys] <= 1'b1;
                    r_state                 <= ST_DONE;
                end
                ST_READ1: begin
                    r_state <= ST_READ2;
                end
                ST_READ2: begin
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item    <= i_q_item;
            r_rd_cell <= '0;
        end
        if (r_state == ST_READ1) begin
            r_rd_vld <= r_row_valid[rd_phys] && !r_item.out_of_range;
            r_rd_col <= rd_col;
        end
        if (r_state == ST_READ2) begin
            r_rd_cell <= (r_rd_vld && (r_rd_col < r_fill_q)) ? r_cell_q : '0;
        end
        if ((r_state == ST_DONE) && out_free) begin
            r_out_data.cursor_index <= ADDR_FIELD_W'(cur_sum);
            r_out_data.read_cell    <= r_rd_cell;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
